// ===== hw/rtl/mi3_pkg.sv =====
// Shared widths, types and cofactor index tables for the 3x3 matrix inverse core.
// No dependencies; every other file in hw/rtl references this package by scope.
package mi3_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int N_ELEM     = 9;

    localparam int PROD_W  = 2 * DATA_WIDTH;
    localparam int COF_W   = 2 * DATA_WIDTH + 1;
    localparam int SPLIT_W = DATA_WIDTH;
    localparam int HI_W    = COF_W - SPLIT_W;
    localparam int PART_W  = DATA_WIDTH + HI_W;
    localparam int TERM_W  = DATA_WIDTH + COF_W;
    localparam int DET_W   = TERM_W + 2;
    localparam int MAG_W   = 2 * DATA_WIDTH;
    localparam int NUM_W   = MAG_W + 2 * FRAC_BITS;
    localparam int QUO_W   = DATA_WIDTH;
    localparam int CMP_W   = DET_W + QUO_W;

    // cofactor, determinant, prep, overflow, divider steps, output
    localparam int LATENCY = QUO_W + 8;

    localparam logic [QUO_W-1:0] SAT_POS = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] SAT_NEG = {1'b1, {(QUO_W-1){1'b0}}};

    typedef logic signed [DATA_WIDTH-1:0] elem_t;
    typedef logic signed [COF_W-1:0]      cof_t;
    typedef logic signed [DET_W-1:0]      det_t;

    // cofactor k = a[CA]*a[CB] - a[CC]*a[CD], already transposed (adjugate order)
    localparam int CA [N_ELEM] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
    localparam int CB [N_ELEM] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
    localparam int CC [N_ELEM] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
    localparam int CD [N_ELEM] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

    typedef struct packed {
        logic                     vld;
        cof_t  [N_ELEM-1:0]       c;
        elem_t [2:0]              row0;
    } cof_bus_t;

    typedef struct packed {
        logic                     vld;
        cof_t  [N_ELEM-1:0]       c;
        det_t                     det;
    } det_bus_t;

    typedef struct packed {
        logic                     vld;
        logic                     sing;
        elem_t [N_ELEM-1:0]       r;
    } res_bus_t;

endpackage

// ===== hw/rtl/mi3_cof.sv =====
// Cofactor stages: 18 signed products, then nine cofactor differences (two stages).
// Depends on mi3_pkg.
module mi3_cof
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  mi3_pkg::elem_t      a [mi3_pkg::N_ELEM],
    output mi3_pkg::cof_bus_t   cof_out
);

    logic signed [mi3_pkg::PROD_W-1:0] pp_reg [mi3_pkg::N_ELEM];
    logic signed [mi3_pkg::PROD_W-1:0] pq_reg [mi3_pkg::N_ELEM];
    mi3_pkg::elem_t                    row0_s1_reg [3];
    mi3_pkg::elem_t                    row0_s2_reg [3];
    mi3_pkg::cof_t                     cof_reg [mi3_pkg::N_ELEM];
    logic                              vld_s1_reg;
    logic                              vld_s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_s1_reg <= 1'b0;
            vld_s2_reg <= 1'b0;
        end
        else
        begin
            vld_s1_reg <= in_vld;
            vld_s2_reg <= vld_s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < mi3_pkg::N_ELEM; k++)
        begin
            pp_reg[k]  <= a[mi3_pkg::CA[k]] * a[mi3_pkg::CB[k]];
            pq_reg[k]  <= a[mi3_pkg::CC[k]] * a[mi3_pkg::CD[k]];
            cof_reg[k] <= mi3_pkg::COF_W'(pp_reg[k]) - mi3_pkg::COF_W'(pq_reg[k]);
        end
        for (int j = 0; j < 3; j++)
        begin
            row0_s1_reg[j] <= a[j];
            row0_s2_reg[j] <= row0_s1_reg[j];
        end
    end

    always_comb
    begin
        cof_out.vld = vld_s2_reg;
        for (int k = 0; k < mi3_pkg::N_ELEM; k++)
        begin
            cof_out.c[k] = cof_reg[k];
        end
        for (int j = 0; j < 3; j++)
        begin
            cof_out.row0[j] = row0_s2_reg[j];
        end
    end

endmodule

// ===== hw/rtl/mi3_det.sv =====
// Determinant stages: first-row expansion with each 65-bit cofactor split into
// two 32x33 partial products, recombined, then summed (three stages). Uses mi3_pkg.
module mi3_det
(
    input  logic                clk,
    input  logic                rst_n,
    input  mi3_pkg::cof_bus_t   cof_in,
    output mi3_pkg::det_bus_t   det_out
);

    logic signed [mi3_pkg::PART_W-1:0] part_lo_reg [3];
    logic signed [mi3_pkg::PART_W-1:0] part_hi_reg [3];
    logic signed [mi3_pkg::TERM_W-1:0] term_reg [3];
    mi3_pkg::det_t                     det_reg;
    mi3_pkg::cof_t                     c_s3_reg [mi3_pkg::N_ELEM];
    mi3_pkg::cof_t                     c_s4_reg [mi3_pkg::N_ELEM];
    mi3_pkg::cof_t                     c_s5_reg [mi3_pkg::N_ELEM];
    logic [2:0]                        vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], cof_in.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            part_lo_reg[j] <= $signed(cof_in.row0[j])
                * $signed({1'b0, cof_in.c[3*j][mi3_pkg::SPLIT_W-1:0]});
            part_hi_reg[j] <= $signed(cof_in.row0[j])
                * $signed(cof_in.c[3*j][mi3_pkg::COF_W-1:mi3_pkg::SPLIT_W]);
            term_reg[j]    <= (mi3_pkg::TERM_W'(part_hi_reg[j]) <<< mi3_pkg::SPLIT_W)
                + mi3_pkg::TERM_W'(part_lo_reg[j]);
        end
        det_reg <= mi3_pkg::DET_W'(term_reg[0]) + mi3_pkg::DET_W'(term_reg[1])
            + mi3_pkg::DET_W'(term_reg[2]);
        for (int k = 0; k < mi3_pkg::N_ELEM; k++)
        begin
            c_s3_reg[k] <= cof_in.c[k];
            c_s4_reg[k] <= c_s3_reg[k];
            c_s5_reg[k] <= c_s4_reg[k];
        end
    end

    always_comb
    begin
        det_out.vld = vld_reg[2];
        det_out.det = det_reg;
        for (int k = 0; k < mi3_pkg::N_ELEM; k++)
        begin
            det_out.c[k] = c_s5_reg[k];
        end
    end

endmodule

// ===== hw/rtl/mi3_div.sv =====
// Nine parallel restoring dividers, one quotient bit per stage, plus magnitude prep,
// overflow check and the saturating output stage. Uses mi3_pkg.
module mi3_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  mi3_pkg::det_bus_t   det_in,
    output mi3_pkg::res_bus_t   res_out
);

    localparam int QW = mi3_pkg::QUO_W;
    localparam int NE = mi3_pkg::N_ELEM;

    // prep stage
    logic [mi3_pkg::NUM_W-1:0] num_p_reg [NE];
    logic [NE-1:0]             neg_p_reg;
    logic [mi3_pkg::DET_W-1:0] dmag_p_reg;
    logic                      sing_p_reg;
    logic                      vld_p_reg;

    // divider stage 0 is the overflow check, stage j produces quotient bit QW-j
    logic [mi3_pkg::NUM_W-1:0] rem_reg  [0:QW][NE];
    logic [QW-1:0]             q_reg    [0:QW][NE];
    logic [NE-1:0]             ovf_reg  [0:QW];
    logic [NE-1:0]             neg_reg  [0:QW];
    logic [mi3_pkg::DET_W-1:0] dmag_reg [0:QW];
    logic                      sing_reg [0:QW];
    logic [QW:0]               vld_reg;

    // output stage
    mi3_pkg::elem_t            r_reg [NE];
    logic                      sing_f_reg;
    logic                      vld_f_reg;

    logic                      dneg;
    logic [mi3_pkg::DET_W-1:0] dmag;
    mi3_pkg::cof_t             cabs [NE];

    always_comb
    begin
        dneg = det_in.det[mi3_pkg::DET_W-1];
        dmag = dneg ? (mi3_pkg::DET_W'(0) - det_in.det) : det_in.det;
        for (int k = 0; k < NE; k++)
        begin
            cabs[k] = det_in.c[k][mi3_pkg::COF_W-1]
                ? (mi3_pkg::COF_W'(0) - det_in.c[k]) : det_in.c[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_p_reg <= 1'b0;
            vld_reg   <= '0;
            vld_f_reg <= 1'b0;
        end
        else
        begin
            vld_p_reg <= det_in.vld;
            vld_reg   <= {vld_reg[QW-1:0], vld_p_reg};
            vld_f_reg <= vld_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        dmag_p_reg <= dmag;
        sing_p_reg <= (det_in.det == '0);
        for (int k = 0; k < NE; k++)
        begin
            num_p_reg[k] <= {cabs[k][mi3_pkg::MAG_W-1:0], {(2*mi3_pkg::FRAC_BITS){1'b0}}};
            neg_p_reg[k] <= det_in.c[k][mi3_pkg::COF_W-1] ^ dneg;
        end
    end

    // overflow: quotient would need more than QW bits
    always_ff @(posedge clk)
    begin
        dmag_reg[0] <= dmag_p_reg;
        sing_reg[0] <= sing_p_reg;
        neg_reg[0]  <= neg_p_reg;
        for (int k = 0; k < NE; k++)
        begin
            rem_reg[0][k] <= num_p_reg[k];
            q_reg[0][k]   <= '0;
            ovf_reg[0][k] <= mi3_pkg::CMP_W'(num_p_reg[k]) >= {dmag_p_reg, {QW{1'b0}}};
        end
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_step
        localparam int SH = QW - j;
        logic [mi3_pkg::CMP_W-1:0] dsh;
        logic [NE-1:0]             fit;

        always_comb
        begin
            dsh = mi3_pkg::CMP_W'(dmag_reg[j-1]) << SH;
            for (int k = 0; k < NE; k++)
            begin
                fit[k] = mi3_pkg::CMP_W'(rem_reg[j-1][k]) >= dsh;
            end
        end

        always_ff @(posedge clk)
        begin
            dmag_reg[j] <= dmag_reg[j-1];
            sing_reg[j] <= sing_reg[j-1];
            neg_reg[j]  <= neg_reg[j-1];
            ovf_reg[j]  <= ovf_reg[j-1];
            for (int k = 0; k < NE; k++)
            begin
                rem_reg[j][k] <= fit[k]
                    ? (rem_reg[j-1][k] - dsh[mi3_pkg::NUM_W-1:0]) : rem_reg[j-1][k];
                q_reg[j][k]   <= q_reg[j-1][k] | (QW'(fit[k]) << SH);
            end
        end
    end

    // saturate against 2^(N-1)-1 or -2^(N-1), then apply sign; a singular word gives zero
    always_ff @(posedge clk)
    begin
        logic [QW-1:0] lim;
        logic [QW-1:0] v;
        sing_f_reg <= sing_reg[QW];
        for (int k = 0; k < NE; k++)
        begin
            lim = neg_reg[QW][k] ? mi3_pkg::SAT_NEG : mi3_pkg::SAT_POS;
            v   = (ovf_reg[QW][k] || (q_reg[QW][k] > lim)) ? lim : q_reg[QW][k];
            if (sing_reg[QW])
            begin
                r_reg[k] <= '0;
            end
            else
            begin
                r_reg[k] <= neg_reg[QW][k] ? (QW'(0) - v) : v;
            end
        end
    end

    always_comb
    begin
        res_out.vld  = vld_f_reg;
        res_out.sing = sing_f_reg;
        for (int k = 0; k < NE; k++)
        begin
            res_out.r[k] = r_reg[k];
        end
    end

endmodule

// ===== hw/rtl/matrix_inverse_3x3_core.sv =====
// 3x3 matrix inverse core (adjugate / determinant), top level.
// Depends on mi3_pkg, mi3_cof, mi3_det and mi3_div.
//
// Usage:
//   Input channel: drive the nine Q16.16 elements a00..a22 and pulse start. A word
//   is taken at every rising edge with start high and busy low. busy is always low,
//   so a new matrix may be sent every cycle.
//   Output channel: done is high for one cycle with r00..r22 and singular valid.
//   Results come out in input order. The receiver has no backpressure.
// Pipeline, from the accepting edge to the edge that takes the result, in order:
//   cofactors, determinant, magnitude prep, overflow check,
//   32 restoring divide steps (one quotient bit per stage), saturate/sign.
// Throughput: one matrix per cycle; the nine dividers are fully unrolled.
// Singular input (determinant zero): singular is set and all outputs are zero.
// Reset (rst_n low, async) clears all in-flight words; done is low afterwards
//   until new words reach the end of the pipeline.
module matrix_inverse_3x3_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  mi3_pkg::elem_t a00,
    input  mi3_pkg::elem_t a01,
    input  mi3_pkg::elem_t a02,
    input  mi3_pkg::elem_t a10,
    input  mi3_pkg::elem_t a11,
    input  mi3_pkg::elem_t a12,
    input  mi3_pkg::elem_t a20,
    input  mi3_pkg::elem_t a21,
    input  mi3_pkg::elem_t a22,
    output logic           done,
    output mi3_pkg::elem_t r00,
    output mi3_pkg::elem_t r01,
    output mi3_pkg::elem_t r02,
    output mi3_pkg::elem_t r10,
    output mi3_pkg::elem_t r11,
    output mi3_pkg::elem_t r12,
    output mi3_pkg::elem_t r20,
    output mi3_pkg::elem_t r21,
    output mi3_pkg::elem_t r22,
    output logic           singular
);

    mi3_pkg::elem_t    a_vec [mi3_pkg::N_ELEM];
    mi3_pkg::cof_bus_t cof_bus;
    mi3_pkg::det_bus_t det_bus;
    mi3_pkg::res_bus_t res_bus;

    assign busy = 1'b0;

    assign a_vec[0] = a00;
    assign a_vec[1] = a01;
    assign a_vec[2] = a02;
    assign a_vec[3] = a10;
    assign a_vec[4] = a11;
    assign a_vec[5] = a12;
    assign a_vec[6] = a20;
    assign a_vec[7] = a21;
    assign a_vec[8] = a22;

    mi3_cof u_cof
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (start && !busy),
        .a       (a_vec),
        .cof_out (cof_bus)
    );

    mi3_det u_det
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cof_in  (cof_bus),
        .det_out (det_bus)
    );

    mi3_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .det_in  (det_bus),
        .res_out (res_bus)
    );

    assign done     = res_bus.vld;
    assign singular = res_bus.sing;
    assign r00      = res_bus.r[0];
    assign r01      = res_bus.r[1];
    assign r02      = res_bus.r[2];
    assign r10      = res_bus.r[3];
    assign r11      = res_bus.r[4];
    assign r12      = res_bus.r[5];
    assign r20      = res_bus.r[6];
    assign r21      = res_bus.r[7];
    assign r22      = res_bus.r[8];

endmodule

// ===== hw/rtl/mi3_chk.sv =====
// Port-level checker for matrix_inverse_3x3_core, bound to the top level below.
// Depends on mi3_pkg and the top level's ports.
module mi3_chk
(
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input mi3_pkg::elem_t a00,
    input mi3_pkg::elem_t a01,
    input mi3_pkg::elem_t a02,
    input mi3_pkg::elem_t a10,
    input mi3_pkg::elem_t a11,
    input mi3_pkg::elem_t a12,
    input mi3_pkg::elem_t a20,
    input mi3_pkg::elem_t a21,
    input mi3_pkg::elem_t a22,
    input logic           done,
    input mi3_pkg::elem_t r00,
    input mi3_pkg::elem_t r01,
    input mi3_pkg::elem_t r02,
    input mi3_pkg::elem_t r10,
    input mi3_pkg::elem_t r11,
    input mi3_pkg::elem_t r12,
    input mi3_pkg::elem_t r20,
    input mi3_pkg::elem_t r21,
    input mi3_pkg::elem_t r22,
    input logic           singular
);

    // every result word traces back to an accepted word a fixed latency earlier
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, mi3_pkg::LATENCY))
        else $error("result word without matching input word");

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("core refused an input word");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular) |-> (r00 == '0 && r01 == '0 && r02 == '0 && r10 == '0
            && r11 == '0 && r12 == '0 && r20 == '0 && r21 == '0 && r22 == '0))
        else $error("singular result with nonzero elements");

endmodule

bind matrix_inverse_3x3_core mi3_chk u_mi3_chk (.*);

// ===== verif/tb_matrix_inverse_3x3_core.sv =====
// Self-checking testbench for matrix_inverse_3x3_core: random and corner matrices,
// predicted inverse compared word by word in arrival order.
// Depends on mi3_pkg and the core RTL.
module tb_matrix_inverse_3x3_core;

    typedef struct {
        mi3_pkg::elem_t m [9];
    } mat_word_t;

    typedef struct {
        mi3_pkg::elem_t r [9];
        logic           sing;
    } inv_word_t;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    logic           done;
    logic           singular;
    mi3_pkg::elem_t a00, a01, a02, a10, a11, a12, a20, a21, a22;
    mi3_pkg::elem_t r00, r01, r02, r10, r11, r12, r20, r21, r22;

    mat_word_t pending_mats [$];
    inv_word_t expected_inv [$];
    int        errors;
    int        cycles;
    int        burst_left;
    int        gap_left;
    bit        stim_done;

    matrix_inverse_3x3_core uut (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Exact adjugate inverse: trunc(C * 2^(2F) / D), saturated.
    function automatic inv_word_t invert_matrix(mat_word_t w);
        inv_word_t           res;
        logic signed [127:0] a [9];
        logic signed [127:0] c [9];
        logic signed [127:0] det;
        logic signed [255:0] num;
        logic signed [255:0] q;
        logic signed [255:0] hi_lim;
        logic signed [255:0] lo_lim;
        hi_lim = (256'sd1 <<< (mi3_pkg::DATA_WIDTH - 1)) - 1;
        lo_lim = -(256'sd1 <<< (mi3_pkg::DATA_WIDTH - 1));
        for (int k = 0; k < 9; k++)
            a[k] = w.m[k];
        c[0] = a[4] * a[8] - a[7] * a[5];
        c[1] = a[2] * a[7] - a[1] * a[8];
        c[2] = a[1] * a[5] - a[2] * a[4];
        c[3] = a[5] * a[6] - a[3] * a[8];
        c[4] = a[0] * a[8] - a[2] * a[6];
        c[5] = a[3] * a[2] - a[0] * a[5];
        c[6] = a[3] * a[7] - a[6] * a[4];
        c[7] = a[6] * a[1] - a[0] * a[7];
        c[8] = a[0] * a[4] - a[3] * a[1];
        det = a[0] * c[0] + a[1] * c[3] + a[2] * c[6];
        res.sing = (det == 0);
        for (int k = 0; k < 9; k++)
        begin
            if (res.sing)
                res.r[k] = '0;
            else
            begin
                num = 256'(c[k]) <<< (2 * mi3_pkg::FRAC_BITS);
                q = num / 256'(det);   // signed division truncates toward zero
                if (q > hi_lim)
                    q = hi_lim;
                else if (q < lo_lim)
                    q = lo_lim;
                res.r[k] = q[mi3_pkg::DATA_WIDTH-1:0];
            end
        end
        return res;
    endfunction

    function automatic mi3_pkg::elem_t rand_elem();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $signed($urandom_range(0, 8)) - 4;
            2: return mi3_pkg::elem_t'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            3: return ($urandom_range(0, 1) != 0) ? mi3_pkg::SAT_POS : mi3_pkg::SAT_NEG;
            default: return mi3_pkg::elem_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    task automatic push_mat(mat_word_t w);
        pending_mats.insert(pending_mats.size(), w);
    endtask

    initial
    begin
        mat_word_t w;
        int        kind;
        // identity, zero, extremes, singular rows, scaled diagonal
        for (int k = 0; k < 9; k++) w.m[k] = (k % 4 == 0) ? 32'sh10000 : 0;
        push_mat(w);
        for (int k = 0; k < 9; k++) w.m[k] = 0;
        push_mat(w);
        for (int k = 0; k < 9; k++) w.m[k] = mi3_pkg::SAT_POS;
        push_mat(w);
        for (int k = 0; k < 9; k++) w.m[k] = mi3_pkg::SAT_NEG;
        push_mat(w);
        for (int k = 0; k < 9; k++) w.m[k] = (k % 4 == 0) ? 32'sd1 : 0;
        push_mat(w);          // tiny det: saturates positive
        w.m[0] = -1;
        push_mat(w);          // r00 saturates negative
        for (int k = 0; k < 9; k++) w.m[k] = (k % 4 == 0) ? mi3_pkg::SAT_NEG : 0;
        push_mat(w);
        for (int k = 0; k < 9; k++)
            w.m[k] = (k % 4 == 0) ? mi3_pkg::SAT_POS : mi3_pkg::SAT_NEG;
        push_mat(w);
        for (int k = 0; k < 9; k++) w.m[k] = 32'hFFFF_FFFF;
        push_mat(w);
        for (int k = 0; k < 9; k++) w.m[k] = 32'(k + 1) <<< 16;
        push_mat(w);          // singular, nonzero elements
        for (int k = 0; k < 9; k++) w.m[k] = (k % 4 == 0) ? 32'sh20000 : 32'sh8000;
        push_mat(w);
        for (int i = 0; i < 1800; i++)
        begin
            kind = $urandom_range(0, 9);
            for (int k = 0; k < 9; k++) w.m[k] = rand_elem();
            if (kind == 0)
                for (int k = 0; k < 3; k++) w.m[6 + k] = w.m[k];  // repeated row
            else if (kind == 1)
                for (int k = 0; k < 3; k++) w.m[3 * k + 2] = 0;   // zero column
            push_mat(w);
        end
    end

    // Driver: bursts of back-to-back words separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        mat_word_t w;
        if (!rst_n)
        begin
            start      <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
            stim_done  <= 1'b0;
            {a00, a01, a02, a10, a11, a12, a20, a21, a22} <= '0;
        end
        else if (start && busy)
            ;
        else
        begin
            if (start)
                expected_inv.insert(expected_inv.size(),
                    invert_matrix('{m: '{a00, a01, a02, a10, a11, a12, a20, a21, a22}}));
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end
            else if (pending_mats.size() == 0)
            begin
                start     <= 1'b0;
                stim_done <= 1'b1;
            end
            else
            begin
                w = pending_mats.pop_front();
                {a00, a01, a02, a10, a11, a12, a20, a21, a22} <=
                    {w.m[0], w.m[1], w.m[2], w.m[3], w.m[4], w.m[5], w.m[6], w.m[7], w.m[8]};
                start <= 1'b1;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // Monitor: done is a one-cycle strobe, no stall possible.
    always @(posedge clk)
    begin
        inv_word_t      exp_w;
        mi3_pkg::elem_t got [9];
        if (rst_n && done)
        begin
            got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
            if (expected_inv.size() == 0)
            begin
                $display("%0t: unexpected word, singular=%0b r00=%0d", $time, singular, r00);
                errors++;
            end
            else
            begin
                exp_w = expected_inv.pop_front();
                if (singular !== exp_w.sing)
                begin
                    $display("%0t: singular exp %0b got %0b", $time, exp_w.sing, singular);
                    errors++;
                end
                for (int k = 0; k < 9; k++)
                    if (got[k] !== exp_w.r[k])
                    begin
                        $display("%0t: r%0d%0d exp %0d got %0d", $time, k / 3, k % 3,
                                 exp_w.r[k], got[k]);
                        errors++;
                    end
            end
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        rst_n  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (!(stim_done && expected_inv.size() == 0) && cycles < 200000)
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= 200000)
        begin
            $display("tb_matrix_inverse_3x3_core: FAIL");
            $finish;
        end
        else
        begin
            repeat (mi3_pkg::LATENCY + 10) @(posedge clk);
            if (errors == 0 && expected_inv.size() == 0)
                $display("tb_matrix_inverse_3x3_core: PASS");
            else
                $display("tb_matrix_inverse_3x3_core: FAIL");
            $finish;
        end
    end
endmodule
